>>> sv/mtrc_pkg.sv
// Shared types and constants for the Modbus TCP response checker.
`default_nettype none

package mtrc_pkg;

	localparam int HEADER_BYTES = 12;
	localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
	localparam int LENGTH_BITS  = 9;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PENDING  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TXN_ID   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNIT_ID  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTITY = 3'd5;

	// Function codes
	localparam logic [7:0] FN_RD_COILS   = 8'h01;
	localparam logic [7:0] FN_RD_REGS    = 8'h03;
	localparam logic [7:0] FN_WR_COILS   = 8'h0F;
	localparam logic [7:0] FN_WR_REGS    = 8'h10;
	localparam logic [7:0] FN_EXC_BIT    = 8'h80;
	localparam logic [7:0] FN_EXC_RD_CL  = 8'h81;
	localparam logic [7:0] FN_EXC_RD_RG  = 8'h83;
	localparam logic [7:0] FN_EXC_WR_CL  = 8'h8F;
	localparam logic [7:0] FN_EXC_WR_RG  = 8'h90;

	// Frame length thresholds
	localparam logic [LENGTH_BITS-1:0] MIN_FRAME_LEN = LENGTH_BITS'(9);
	localparam logic [LENGTH_BITS-1:0] MIN_READ_LEN  = LENGTH_BITS'(10);
	localparam logic [LENGTH_BITS-1:0] WRITE_LEN     = LENGTH_BITS'(12);
	localparam logic [LENGTH_BITS-1:0] MBAP_PREFIX   = LENGTH_BITS'(6);
	localparam logic [LENGTH_BITS-1:0] READ_PREFIX   = LENGTH_BITS'(9);

	typedef enum logic [4:0] {
		ST_NO_REQ     = 5'd0,
		ST_SHORT      = 5'd1,
		ST_TXN        = 5'd2,
		ST_PROTO      = 5'd3,
		ST_LEN_FIELD  = 5'd4,
		ST_UNIT       = 5'd5,
		ST_FUNC       = 5'd6,
		ST_READ_SHORT = 5'd7,
		ST_COUNT      = 5'd8,
		ST_BYTES      = 5'd9,
		ST_RD_COIL_OK = 5'd10,
		ST_RD_REG_OK  = 5'd11,
		ST_ADDR       = 5'd12,
		ST_QTY        = 5'd13,
		ST_WR_LEN     = 5'd14,
		ST_WR_COIL_OK = 5'd15,
		ST_WR_REG_OK  = 5'd16,
		ST_EXC_FUNC   = 5'd17,
		ST_EXCEPTION  = 5'd18,
		ST_UNKNOWN    = 5'd19
	} status_t;

	typedef struct packed {
		logic [7:0] resp_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		status_t                status;
		logic [LENGTH_BITS-1:0] response_length;
	} out_item_t;

	typedef struct packed {
		logic        request_pending;
		logic [15:0] req_transaction_id;
		logic [7:0]  req_unit_id;
		logic [7:0]  req_function;
		logic [15:0] req_start_address;
		logic [15:0] req_quantity;
	} req_t;

	typedef logic [HEADER_BYTES-1:0][7:0] hdr_t;

	// Frame tracker to evaluator
	typedef struct packed {
		hdr_t                   hdr;
		logic [LENGTH_BITS-1:0] len;
		logic                   done;
	} frame_t;

endpackage

`default_nettype wire

>>> sv/modbus_tcp_response_checker_core.sv
// Top level of the Modbus TCP response checker: config registers and result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | input     | in_valid / in_ready | in_data: resp_byte, last_byte
//  out     | output    | out_valid/out_ready | out_data: status, response_length
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (write only)
//
// One response byte per cycle is taken while the input stage is not held. A byte
// waits in the input register, where it is stored into the 12-byte header and
// counted; on the final byte the checks run in that same cycle and the status
// lands in the output register.
// A held output stalls only when a new status must replace it; plain bytes
// keep flowing. Reset clears the counter, handshake state and config;
// the header store has no reset and needs no clearing pass.
`default_nettype none

module modbus_tcp_response_checker_core
	import mtrc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	req_t      req_q;
	frame_t    frame;
	status_t   status;
	logic      advance;
	logic      out_valid_q;
	out_item_t out_q;

	// Config writes are taken at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PENDING:  req_q.request_pending    <= cfg_data[0];
				CFG_TXN_ID:   req_q.req_transaction_id <= cfg_data;
				CFG_UNIT_ID:  req_q.req_unit_id        <= cfg_data[7:0];
				CFG_FUNCTION: req_q.req_function       <= cfg_data[7:0];
				CFG_START:    req_q.req_start_address  <= cfg_data;
				CFG_QUANTITY: req_q.req_quantity       <= cfg_data;
				default: ;    // unused index, ignored
			endcase
		end
	end

	// Input stage moves on unless it holds a final byte and the output is full
	assign advance = !(frame.done && out_valid_q && !out_ready);

	mtrc_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.frame    (frame)
	);

	mtrc_eval u_eval (
		.req    (req_q),
		.frame  (frame),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame.done && advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.done && advance) begin
			out_q.status          <= status;
			out_q.response_length <= frame.len;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> sv/mtrc_frame.sv
// Input register, header byte store and saturating byte counter.
`default_nettype none

module mtrc_frame
	import mtrc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	input  wire logic     advance,
	output frame_t        frame
);

	logic                   valid_s1;
	in_item_t               data_s1;
	hdr_t                   hdr_q;
	logic [LENGTH_BITS-1:0] pos_q;
	logic [LENGTH_BITS-1:0] next_len;
	logic                   step;

	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;
	assign next_len = (pos_q == LEN_MAX) ? pos_q : pos_q + LENGTH_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				pos_q <= data_s1.last_byte ? '0 : next_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
		if (step && pos_q < LENGTH_BITS'(HEADER_BYTES)) begin
			hdr_q[pos_q[HDR_IDX_W-1:0]] <= data_s1.resp_byte;
		end
	end

	// Header as seen with the current byte already in place
	always_comb begin
		for (int i = 0; i < HEADER_BYTES; i++) begin
			frame.hdr[i] = (pos_q == LENGTH_BITS'(i)) ? data_s1.resp_byte : hdr_q[i];
		end
		frame.len  = next_len;
		frame.done = valid_s1 && data_s1.last_byte;
	end

endmodule

`default_nettype wire

>>> sv/mtrc_eval.sv
// Response checks against the pending request, giving one status code.
`default_nettype none

module mtrc_eval
	import mtrc_pkg::*;
(
	input  wire req_t   req,
	input  wire frame_t frame,
	output status_t     status
);

	logic [15:0]            txn_id;
	logic [15:0]            mbap_len;
	logic [15:0]            wr_addr;
	logic [15:0]            wr_qty;
	logic [7:0]             fn;
	logic [7:0]             byte_cnt;
	logic [16:0]            qty_plus7;
	logic [15:0]            expect_cnt;
	logic [LENGTH_BITS-1:0] len;
	logic                   is_read;
	logic                   is_write;
	logic                   is_exc;

	always_comb begin
		len       = frame.len;
		txn_id    = {frame.hdr[0], frame.hdr[1]};
		mbap_len  = {frame.hdr[4], frame.hdr[5]};
		wr_addr   = {frame.hdr[8], frame.hdr[9]};
		wr_qty    = {frame.hdr[10], frame.hdr[11]};
		fn        = frame.hdr[7];
		byte_cnt  = frame.hdr[8];
		qty_plus7 = {1'b0, req.req_quantity} + 17'd7;
		// coils: ceil(qty/8); registers: 2*qty kept to 16 bits
		expect_cnt = (fn == FN_RD_COILS) ? {2'b00, qty_plus7[16:3]}
		                                 : {req.req_quantity[14:0], 1'b0};
		is_read  = (fn == FN_RD_COILS) || (fn == FN_RD_REGS);
		is_write = (fn == FN_WR_COILS) || (fn == FN_WR_REGS);
		is_exc   = (fn == FN_EXC_RD_CL) || (fn == FN_EXC_RD_RG) ||
		           (fn == FN_EXC_WR_CL) || (fn == FN_EXC_WR_RG);

		priority if (!req.request_pending) begin
			status = ST_NO_REQ;
		end else if (len < MIN_FRAME_LEN) begin
			status = ST_SHORT;
		end else if (txn_id != req.req_transaction_id) begin
			status = ST_TXN;
		end else if ((frame.hdr[2] | frame.hdr[3]) != 8'h00) begin
			status = ST_PROTO;
		end else if (16'(len - MBAP_PREFIX) != mbap_len) begin
			status = ST_LEN_FIELD;
		end else if (frame.hdr[6] != req.req_unit_id) begin
			status = ST_UNIT;
		end else if ((is_read || is_write) && fn != req.req_function) begin
			status = ST_FUNC;
		end else if (is_read) begin
			priority if (len < MIN_READ_LEN) begin
				status = ST_READ_SHORT;
			end else if (expect_cnt != {8'h00, byte_cnt}) begin
				status = ST_COUNT;
			end else if (LENGTH_BITS'(byte_cnt) != len - READ_PREFIX) begin
				status = ST_BYTES;
			end else begin
				status = (fn == FN_RD_COILS) ? ST_RD_COIL_OK : ST_RD_REG_OK;
			end
		end else if (is_write) begin
			priority if (len != WRITE_LEN) begin
				status = ST_WR_LEN;
			end else if (wr_addr != req.req_start_address) begin
				status = ST_ADDR;
			end else if (wr_qty != req.req_quantity) begin
				status = ST_QTY;
			end else begin
				status = (fn == FN_WR_COILS) ? ST_WR_COIL_OK : ST_WR_REG_OK;
			end
		end else if (is_exc) begin
			status = ((fn - FN_EXC_BIT) != req.req_function) ? ST_EXC_FUNC : ST_EXCEPTION;
		end else begin
			status = ST_UNKNOWN;
		end
	end

endmodule

`default_nettype wire

>>> sv/mtrc_checker.sv
// Port-level assertions for the response checker, bound to the top level.
`default_nettype none

module mtrc_checker
	import mtrc_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	// A stalled status holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// Every frame has at least one byte
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.response_length != '0)
		else $error("zero frame length reported");

	// Anything past the short check saw a full MBAP header
	a_len_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_NO_REQ && out_data.status != ST_SHORT
		|-> out_data.response_length >= MIN_FRAME_LEN)
		else $error("check passed on a short frame");

	// Write echo accepted only at exactly 12 bytes
	a_write_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_WR_COIL_OK || out_data.status == ST_WR_REG_OK ||
		              out_data.status == ST_ADDR || out_data.status == ST_QTY)
		|-> out_data.response_length == WRITE_LEN)
		else $error("write echo status with wrong length");

	// Short status only for frames under the minimum
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_SHORT
		|-> out_data.response_length < MIN_FRAME_LEN)
		else $error("short status on a long frame");

endmodule

bind modbus_tcp_response_checker_core mtrc_checker u_mtrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

>>> verif/tb_modbus_tcp_response_checker_core.sv
// Testbench for the Modbus TCP response checker: streams response frames against loaded requests.
`timescale 1ns / 100ps

module tb_modbus_tcp_response_checker_core;
	import mtrc_pkg::*;

	// Unused register slots; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_GUARD = 200000;

	// How a generated frame is damaged after it is built.
	typedef enum int {
		FLT_NONE,
		FLT_TXN,     // flip a bit of the transaction id
		FLT_PROTO,   // nonzero protocol id
		FLT_LENF,    // MBAP length field off
		FLT_UNIT,    // wrong unit id
		FLT_DROP,    // drop tail bytes, length field follows
		FLT_CUT,     // drop tail bytes after the length field is set
		FLT_BODY_LO, // flip a bit of byte 8 (count or address)
		FLT_BODY_HI  // flip a bit of byte 10 (quantity)
	} fault_t;

	typedef logic [7:0] octet_q_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	modbus_tcp_response_checker_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------------------------------
	// Shadow of the block: request registers, captured header and byte counter.
	// ---------------------------------------------------------------------------------------
	req_t req_regs = '0;
	logic [7:0] hdr_copy [HEADER_BYTES];
	logic [LENGTH_BITS-1:0] hdr_fill = '0;

	in_item_t byte_feed[$];   // response bytes waiting for the driver
	out_item_t status_due[$]; // statuses owed by the block, oldest first
	octet_q_t frame;          // frame under construction
	int queued_bytes = 0;
	int faults = 0;
	int send_gap = 0;         // percent of free slots the sender leaves empty
	int recv_stall = 0;       // percent of cycles the receiver holds off
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;

	// Status for a frame of the given (saturated) length, checks in priority order.
	function automatic status_t judge_frame(input logic [LENGTH_BITS-1:0] len);
		logic [7:0] code;
		logic [15:0] want;
		code = hdr_copy[7];
		if (!req_regs.request_pending)
			return ST_NO_REQ;
		if (len < MIN_FRAME_LEN)
			return ST_SHORT;
		if ({hdr_copy[0], hdr_copy[1]} != req_regs.req_transaction_id)
			return ST_TXN;
		if (hdr_copy[2] != 8'h00 || hdr_copy[3] != 8'h00)
			return ST_PROTO;
		if (16'(len - MBAP_PREFIX) != {hdr_copy[4], hdr_copy[5]})
			return ST_LEN_FIELD;
		if (hdr_copy[6] != req_regs.req_unit_id)
			return ST_UNIT;
		case (code)
			FN_RD_COILS, FN_RD_REGS: begin
				if (code != req_regs.req_function)
					return ST_FUNC;
				if (len < MIN_READ_LEN)
					return ST_READ_SHORT;
				// coils: one bit each, rounded up; registers: two bytes each, 16-bit wrap
				if (code == FN_RD_COILS)
					want = 16'((int'(req_regs.req_quantity) + 7) / 8);
				else
					want = {req_regs.req_quantity[14:0], 1'b0};
				if (want != 16'(hdr_copy[8]))
					return ST_COUNT;
				if (9'(hdr_copy[8]) != len - READ_PREFIX)
					return ST_BYTES;
				return (code == FN_RD_COILS) ? ST_RD_COIL_OK : ST_RD_REG_OK;
			end
			FN_WR_COILS, FN_WR_REGS: begin
				if (code != req_regs.req_function)
					return ST_FUNC;
				if (len != WRITE_LEN)
					return ST_WR_LEN;
				if ({hdr_copy[8], hdr_copy[9]} != req_regs.req_start_address)
					return ST_ADDR;
				if ({hdr_copy[10], hdr_copy[11]} != req_regs.req_quantity)
					return ST_QTY;
				return (code == FN_WR_COILS) ? ST_WR_COIL_OK : ST_WR_REG_OK;
			end
			FN_EXC_RD_CL, FN_EXC_RD_RG, FN_EXC_WR_CL, FN_EXC_WR_RG: begin
				return (code - FN_EXC_BIT != req_regs.req_function) ? ST_EXC_FUNC : ST_EXCEPTION;
			end
			default: begin
				return ST_UNKNOWN;
			end
		endcase
	endfunction

	// One accepted byte: store it while inside the header, count it, judge on the marker.
	task automatic absorb_byte(input in_item_t item);
		out_item_t owed;
		if (hdr_fill < HEADER_BYTES)
			hdr_copy[hdr_fill] = item.resp_byte;
		if (hdr_fill != LEN_MAX)
			hdr_fill++;
		if (item.last_byte) begin
			owed.status = judge_frame(hdr_fill);
			owed.response_length = hdr_fill;
			status_due.push_back(owed);
			hdr_fill = '0;
		end
	endtask

	// ---------------------------------------------------------------------------------------
	// Driver: feeds byte_feed into the input channel, with random gaps.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				absorb_byte(in_data);
			// slot is free once the held item went through (or nothing was held)
			if (!in_valid || in_ready) begin
				if (byte_feed.size() != 0 && $urandom_range(99) >= send_gap) begin
					in_data <= byte_feed.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, armed by the stimulus process.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asked) begin
			hold_taken <= hold_asked;
			hold_left <= HOLD_CYCLES;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Monitor: random back-pressure, every accepted status checked against the oldest owed.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (status_due.size() == 0) begin
					$display("%0t: status %0d length %0d arrived with none expected",
						$time, out_data.status, out_data.response_length);
					faults++;
				end else begin
					want = status_due.pop_front();
					if (out_data.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, out_data.status);
						faults++;
					end
					if (out_data.response_length !== want.response_length) begin
						$display("%0t: response_length expected %0d actual %0d",
							$time, want.response_length, out_data.response_length);
						faults++;
					end
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall);
		end
	end

	// ---------------------------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_PENDING:  req_regs.request_pending = val[0];
			CFG_TXN_ID:   req_regs.req_transaction_id = val;
			CFG_UNIT_ID:  req_regs.req_unit_id = val[7:0];
			CFG_FUNCTION: req_regs.req_function = val[7:0];
			CFG_START:    req_regs.req_start_address = val;
			CFG_QUANTITY: req_regs.req_quantity = val;
			default: ;
		endcase
	endtask

	// Narrow registers get junk in the unused upper bits; spare slots get random writes.
	task automatic load_request(input logic pend, input logic [15:0] txn, input logic [7:0] unit,
			input logic [7:0] code, input logic [15:0] start, input logic [15:0] qty);
		write_reg(CFG_PENDING, {15'($urandom), pend});
		write_reg(CFG_TXN_ID, txn);
		write_reg(CFG_UNIT_ID, {8'($urandom), unit});
		write_reg(CFG_FUNCTION, {8'($urandom), code});
		write_reg(CFG_START, start);
		write_reg(CFG_QUANTITY, qty);
		write_reg(CFG_SPARE_A, 16'($urandom));
		write_reg(CFG_SPARE_B, 16'($urandom));
		@(negedge clk);
	endtask

	task automatic ship_frame();
		in_item_t item;
		foreach (frame[i]) begin
			item.resp_byte = frame[i];
			item.last_byte = (i == frame.size() - 1);
			byte_feed.push_back(item);
		end
		queued_bytes += frame.size();
	endtask

	task automatic flip_bit(input int idx);
		if (idx < frame.size())
			frame[idx] ^= 8'(1 << $urandom_range(7));
	endtask

	// Response to the loaded request with the given code, then damaged as asked.
	// extra pads the tail before the length field is set (long frames).
	task automatic queue_frame(input logic [7:0] code, input fault_t flt, input int extra);
		logic [15:0] want;
		int n;
		frame = {};
		frame.push_back(req_regs.req_transaction_id[15:8]);
		frame.push_back(req_regs.req_transaction_id[7:0]);
		repeat (4)
			frame.push_back(8'h00);
		frame.push_back(req_regs.req_unit_id);
		frame.push_back(code);
		case (code)
			FN_RD_COILS, FN_RD_REGS: begin
				if (code == FN_RD_COILS)
					want = 16'((int'(req_regs.req_quantity) + 7) / 8);
				else
					want = {req_regs.req_quantity[14:0], 1'b0};
				frame.push_back(want[7:0]);
				repeat (int'(want[7:0]))
					frame.push_back(8'($urandom));
			end
			FN_WR_COILS, FN_WR_REGS: begin
				frame.push_back(req_regs.req_start_address[15:8]);
				frame.push_back(req_regs.req_start_address[7:0]);
				frame.push_back(req_regs.req_quantity[15:8]);
				frame.push_back(req_regs.req_quantity[7:0]);
			end
			FN_EXC_RD_CL, FN_EXC_RD_RG, FN_EXC_WR_CL, FN_EXC_WR_RG: begin
				frame.push_back(8'($urandom_range(1, 4)));
			end
			default: begin
				repeat ($urandom_range(0, 3))
					frame.push_back(8'($urandom));
			end
		endcase
		repeat (extra)
			frame.push_back(8'($urandom));
		if (flt == FLT_DROP) begin
			repeat ($urandom_range(1, 3))
				if (frame.size() > 1)
					void'(frame.pop_back());
		end
		// MBAP length counts from the unit id on, capped like the block's counter
		n = (frame.size() > int'(LEN_MAX)) ? int'(LEN_MAX) : frame.size();
		n -= 6;
		if (frame.size() > 5) begin
			frame[4] = 8'(n >> 8);
			frame[5] = 8'(n);
		end
		case (flt)
			FLT_TXN:     flip_bit($urandom_range(0, 1));
			FLT_PROTO:   flip_bit($urandom_range(2, 3));
			FLT_LENF:    flip_bit($urandom_range(4, 5));
			FLT_UNIT:    flip_bit(6);
			FLT_BODY_LO: flip_bit(8);
			FLT_BODY_HI: flip_bit(10);
			FLT_CUT: begin
				repeat ($urandom_range(1, 4))
					if (frame.size() > 1)
						void'(frame.pop_back());
			end
			default: ;
		endcase
		ship_frame();
	endtask

	task automatic queue_noise(input int len);
		frame = {};
		repeat (len)
			frame.push_back(8'($urandom));
		ship_frame();
	endtask

	function automatic logic [7:0] any_code();
		case ($urandom_range(3))
			0: return FN_RD_COILS;
			1: return FN_RD_REGS;
			2: return FN_WR_COILS;
			default: return FN_WR_REGS;
		endcase
	endfunction

	function automatic logic is_data_code(input logic [7:0] code);
		return code == FN_RD_COILS || code == FN_RD_REGS || code == FN_WR_COILS
			|| code == FN_WR_REGS;
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_request();
		logic [7:0] code;
		logic [15:0] qty;
		code = ($urandom_range(9) < 8) ? any_code() : 8'($urandom);
		// reads keep the count small so frames stay short; a full quantity now and then
		if ($urandom_range(7) == 0)
			qty = 16'hFFFF;
		else if (code == FN_RD_COILS)
			qty = 16'($urandom_range(0, 40));
		else if (code == FN_RD_REGS)
			qty = 16'($urandom_range(0, 12));
		else
			qty = pick_word();
		load_request($urandom_range(9) != 0, pick_word(), 8'(pick_word()), code, pick_word(), qty);
	endtask

	// Well-formed answers to the request, mixed with noise, wrong codes and damage.
	task automatic random_frame();
		logic [7:0] base;
		logic [7:0] code;
		int r;
		fault_t flt;
		r = $urandom_range(99);
		if (r < 8) begin
			queue_noise($urandom_range(1, 16));
		end else begin
			base = is_data_code(req_regs.req_function) ? req_regs.req_function : any_code();
			r = $urandom_range(99);
			if (r < 62)
				code = base;
			else if (r < 77)
				code = base | FN_EXC_BIT;
			else if (r < 90)
				code = any_code();
			else
				code = 8'($urandom);
			flt = ($urandom_range(99) < 55) ? FLT_NONE : fault_t'($urandom_range(1, FLT_BODY_HI));
			queue_frame(code, flt, ($urandom_range(199) == 0) ? $urandom_range(500, 560) : 0);
		end
	endtask

	// Wait for everything sent and owed to clear, then the pipeline tail.
	task automatic settle();
		int guard;
		guard = 0;
		while ((byte_feed.size() != 0 || in_valid || status_due.size() != 0)
				&& guard < SETTLE_GUARD) begin
			@(negedge clk);
			guard++;
		end
		repeat (4)
			@(negedge clk);
		if (status_due.size() != 0) begin
			$display("%0t: %0d status item(s) never arrived", $time, status_due.size());
			faults++;
			status_due.delete();
		end
	endtask

	task automatic set_idling(input int gap, input int stall);
		send_gap = gap;
		recv_stall = stall;
	endtask

	// ---------------------------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------------------------
	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset config: nothing pending
		queue_frame(FN_RD_REGS, FLT_NONE, 0);
		settle();

		// coil read of zero quantity: count byte 0 gives a 9-byte frame, too short for a read
		load_request(1'b1, 16'h0000, 8'h00, FN_RD_COILS, 16'h0000, 16'h0000);
		queue_frame(FN_RD_COILS, FLT_NONE, 0);
		queue_noise(1);
		queue_noise(8);
		queue_frame(FN_EXC_RD_CL, FLT_NONE, 0);  // exception, matching function
		queue_frame(FN_EXC_RD_RG, FLT_NONE, 0);  // exception for another function
		queue_frame(FN_WR_COILS, FLT_NONE, 0);   // function mismatch
		queue_frame(FN_EXC_BIT, FLT_NONE, 0);    // unknown code
		settle();

		// register read with transaction id, unit id and start address at their top values
		load_request(1'b1, 16'hFFFF, 8'hFF, FN_RD_REGS, 16'hFFFF, 16'h0003);
		queue_frame(FN_RD_REGS, FLT_NONE, 0);
		queue_frame(FN_RD_REGS, FLT_TXN, 0);
		queue_frame(FN_RD_REGS, FLT_PROTO, 0);
		queue_frame(FN_RD_REGS, FLT_LENF, 0);
		queue_frame(FN_RD_REGS, FLT_UNIT, 0);
		queue_frame(FN_RD_REGS, FLT_BODY_LO, 0); // byte count wrong
		queue_frame(FN_RD_REGS, FLT_NONE, 1);    // one data byte too many
		// long frame: runs into saturation and past it, the count holds
		queue_frame(FN_RD_REGS, FLT_NONE, int'(LEN_MAX) - 6);
		settle();

		load_request(1'b1, 16'h1234, 8'h11, FN_RD_COILS, 16'h0000, 16'h0009);
		queue_frame(FN_RD_COILS, FLT_NONE, 0);
		queue_frame(FN_RD_COILS, FLT_DROP, 0);
		settle();

		load_request(1'b1, 16'hA55A, 8'h3C, FN_WR_COILS, 16'hFFFF, 16'hFFFF);
		queue_frame(FN_WR_COILS, FLT_NONE, 0);
		queue_frame(FN_WR_COILS, FLT_BODY_LO, 0); // address echo wrong
		queue_frame(FN_WR_COILS, FLT_BODY_HI, 0); // quantity echo wrong
		queue_frame(FN_WR_COILS, FLT_NONE, 1);    // echo not 12 bytes
		queue_frame(FN_EXC_WR_CL, FLT_NONE, 0);
		queue_frame(FN_WR_REGS, FLT_NONE, 0);
		settle();

		load_request(1'b1, 16'($urandom), 8'($urandom), FN_WR_REGS, 16'h0000, 16'h0000);
		queue_frame(FN_WR_REGS, FLT_NONE, 0);
		queue_frame(FN_EXC_WR_RG, FLT_NONE, 0);
		settle();

		// random phases, each with a new request and its own idling mix
		for (int ph = 0; ph < 8; ph++) begin
			random_request();
			case (ph % 4)
				0: set_idling(0, 0);
				1: set_idling(66, 0);
				2: set_idling(0, 66);
				default: set_idling(30, 30);
			endcase
			if (ph == 4) begin
				// receiver goes quiet while bytes keep coming: the block must back up
				set_idling(0, 0);
				hold_asked++;
			end
			queued_bytes = 0;
			while (queued_bytes < 50)
				random_frame();
			settle();
		end

		repeat (8)
			@(negedge clk);
		if (faults == 0)
			$display("modbus_tcp_response_checker_core: match");
		else
			$display("modbus_tcp_response_checker_core: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#12_000_000;
		$display("modbus_tcp_response_checker_core: mismatch");
		$finish;
	end

endmodule

>>> modbus_tcp_response_checker_core.f
sv/mtrc_pkg.sv
sv/mtrc_frame.sv
sv/mtrc_eval.sv
sv/modbus_tcp_response_checker_core.sv
sv/mtrc_checker.sv
verif/tb_modbus_tcp_response_checker_core.sv
